@@ hw/rtl/bsw_pkg.sv @@
`timescale 1ns / 1ps
package bsw_pkg;

  localparam int CNT_BITS   = 7;
  localparam int QUANT_BITS = 16;
  localparam int PRIO_BITS  = 8;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;
  localparam logic [1:0] MODE_RR   = 2'd3;

  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // one loaded batch handed from loader to scheduler
  typedef struct packed {
    logic [CNT_BITS-1:0]   n;
    logic [1:0]            mode;
    logic [QUANT_BITS-1:0] quantum;
  } batch_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;

endpackage

@@ hw/rtl/bsw_in_if.sv @@
`timescale 1ns / 1ps
interface bsw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] burst_time;
  logic [7:0]  job_priority;
  logic        last_job;

  modport source (output valid, burst_time, job_priority, last_job, input ready);
  modport sink (input valid, burst_time, job_priority, last_job, output ready);
endinterface

@@ hw/rtl/bsw_out_if.sv @@
`timescale 1ns / 1ps
interface bsw_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  job_index;
  logic [21:0] wait_time;
  logic [21:0] turnaround;
  logic [27:0] total_wait;
  logic        last_result;

  modport source (output valid, job_index, wait_time, turnaround, total_wait, last_result,
                  input ready);
  modport sink (input valid, job_index, wait_time, turnaround, total_wait, last_result,
                output ready);
endinterface

@@ hw/rtl/batch_schedule_wait_times_top.sv @@
`timescale 1ns / 1ps
// Batch job scheduler: waiting and turnaround times.
// jobs_i takes one job word per cycle (burst, priority, last flag); the word
// with last_job set, or the one that fills MAX_JOBS, closes the batch.
// While the batch is scheduled jobs_i.ready stays low; it rises again after
// the final result word has been loaded into the output register.
// results_o gives one word per job: FCFS, SJF and priority in run order,
// round robin in load order; the last word carries total_wait and last_result.
// Modes 0-2 pick each job by a scan over the burst/priority memories. Round
// robin computes each job's finish time with a bit-serial remainder and one
// scan.
// A stalled receiver holds the result register and the scheduler waits.
// Reset empties the loader, the batch queue and the output register and sets
// sched_mode to 0 and time_quantum to 1. Write registers over APB only while
// the block is idle: 0x0 sched_mode, 0x4 time_quantum.
module batch_schedule_wait_times_top #(
  parameter int MAX_JOBS   = 64,
  parameter int BURST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsw_in_if.sink      jobs_i,
  bsw_out_if.source   results_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_JOBS);

  logic [1:0]                    mode_q, mode_d;
  logic [bsw_pkg::QUANT_BITS-1:0] quant_q, quant_d;
  logic                          cfg_wr;

  logic                          push, full, pop, empty;
  bsw_pkg::batch_t               batch_w, batch_r;
  logic                          we;
  logic [IW-1:0]                 waddr, raddr;
  logic [BURST_BITS-1:0]         wburst, rburst;
  logic [bsw_pkg::PRIO_BITS-1:0] wprio, rprio;
  bsw_pkg::back_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bsw_pkg::REG_MODE) ? 32'(mode_q) : 32'(quant_q);

  always_comb begin
    mode_d  = mode_q;
    quant_d = quant_q;
    if (cfg_wr) begin
      if (paddr[2] == bsw_pkg::REG_MODE) begin
        mode_d = pwdata[1:0];
      end else begin
        quant_d = pwdata[bsw_pkg::QUANT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bsw_pkg::MODE_FCFS;
      quant_q <= bsw_pkg::QUANT_BITS'(1);
    end else begin
      mode_q  <= mode_d;
      quant_q <= quant_d;
    end
  end

  bsw_front #(.MAX_JOBS(MAX_JOBS), .BURST_BITS(BURST_BITS)) u_front (
    .clk_i, .rst_ni, .jobs_i,
    .mode_i(mode_q), .quantum_i(quant_q),
    .push_o(push), .batch_o(batch_w), .full_i(full),
    .we_o(we), .waddr_o(waddr), .wburst_o(wburst), .wprio_o(wprio),
    .stat_i(stat)
  );

  bsw_fifo #(.WIDTH($bits(bsw_pkg::batch_t))) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(batch_w), .full_o(full),
    .pop_i(pop), .rdata_o(batch_r), .empty_o(empty)
  );

  bsw_ram #(.WIDTH(BURST_BITS), .DEPTH(MAX_JOBS)) u_burst_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wburst),
    .raddr_i(raddr), .rdata_o(rburst)
  );

  bsw_ram #(.WIDTH(bsw_pkg::PRIO_BITS), .DEPTH(MAX_JOBS)) u_prio_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wprio),
    .raddr_i(raddr), .rdata_o(rprio)
  );

  bsw_back #(.MAX_JOBS(MAX_JOBS), .BURST_BITS(BURST_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .batch_i(batch_r), .pop_o(pop),
    .raddr_o(raddr), .rburst_i(rburst), .rprio_i(rprio),
    .results_o, .stat_o(stat)
  );

  // no job is loaded while the scheduler reads the stores
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jobs_i.valid && jobs_i.ready) |-> !stat.busy)
    else $error("job accepted while scheduler busy");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && !results_o.ready) |=>
      (results_o.valid && $stable(results_o.job_index) && $stable(results_o.wait_time)
       && $stable(results_o.turnaround) && $stable(results_o.total_wait)
       && $stable(results_o.last_result)))
    else $error("result word changed while stalled");

  a_wait_le_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    results_o.valid |-> (results_o.wait_time <= results_o.turnaround))
    else $error("wait exceeds turnaround");

endmodule

@@ hw/rtl/bsw_ram.sv @@
`timescale 1ns / 1ps
module bsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bsw_fifo.sv @@
`timescale 1ns / 1ps
module bsw_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/bsw_front.sv @@
`timescale 1ns / 1ps
module bsw_front #(
  parameter int MAX_JOBS   = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bsw_in_if.sink                        jobs_i,
  input  logic [1:0]                    mode_i,
  input  logic [bsw_pkg::QUANT_BITS-1:0] quantum_i,
  output logic                          push_o,
  output bsw_pkg::batch_t               batch_o,
  input  logic                          full_i,
  output logic                          we_o,
  output logic [$clog2(MAX_JOBS)-1:0]   waddr_o,
  output logic [BURST_BITS-1:0]         wburst_o,
  output logic [bsw_pkg::PRIO_BITS-1:0] wprio_o,
  input  bsw_pkg::back_stat_t           stat_i
);

  localparam int IW = $clog2(MAX_JOBS);

  logic [bsw_pkg::CNT_BITS-1:0] count_q, count_d;
  logic                         pend_q, pend_d;
  logic [bsw_pkg::CNT_BITS-1:0] n_next;
  logic                         accept, last;

  assign jobs_i.ready = !pend_q && !full_i;
  assign accept       = jobs_i.valid && jobs_i.ready;
  assign n_next       = count_q + bsw_pkg::CNT_BITS'(1);
  // a full store closes the batch as well
  assign last         = jobs_i.last_job || (n_next == bsw_pkg::CNT_BITS'(MAX_JOBS));

  assign we_o     = accept;
  assign waddr_o  = count_q[IW-1:0];
  assign wburst_o = BURST_BITS'(jobs_i.burst_time);
  assign wprio_o  = jobs_i.job_priority;

  assign push_o          = accept && last;
  assign batch_o.n       = n_next;
  assign batch_o.mode    = mode_i;
  assign batch_o.quantum = (quantum_i == '0) ? bsw_pkg::QUANT_BITS'(1) : quantum_i;

  always_comb begin
    count_d = count_q;
    pend_d  = pend_q;
    if (stat_i.done) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (last) begin
        count_d = '0;
        pend_d  = 1'b1;
      end else begin
        count_d = n_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ hw/rtl/bsw_back.sv @@
`timescale 1ns / 1ps
module bsw_back #(
  parameter int MAX_JOBS   = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  bsw_pkg::batch_t               batch_i,
  output logic                          pop_o,
  output logic [$clog2(MAX_JOBS)-1:0]   raddr_o,
  input  logic [BURST_BITS-1:0]         rburst_i,
  input  logic [bsw_pkg::PRIO_BITS-1:0] rprio_i,
  bsw_out_if.source                     results_o,
  output bsw_pkg::back_stat_t           stat_o
);

  localparam int IW  = $clog2(MAX_JOBS);
  localparam int CW  = bsw_pkg::CNT_BITS;
  localparam int QW  = bsw_pkg::QUANT_BITS;
  localparam int TW  = BURST_BITS + CW;
  localparam int TTW = TW + CW;
  localparam int LW  = ((BURST_BITS > QW) ? BURST_BITS : QW) + 1;
  localparam int KW  = (BURST_BITS > bsw_pkg::PRIO_BITS) ? BURST_BITS : bsw_pkg::PRIO_BITS;
  localparam int DCW = $clog2(BURST_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LDI  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LIM  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         n_q, n_d, k_q, k_d, j_q, j_d, ridx_q, ridx_d, bidx_q, bidx_d;
  logic [1:0]            mode_q, mode_d;
  logic [QW-1:0]         q_q, q_d;
  logic                  rv_q, rv_d, bv_q, bv_d;
  logic                  pv_q, pv_d;
  logic [KW-1:0]         pkey_q, pkey_d;
  logic [CW-1:0]         pidx_q, pidx_d;
  logic [KW-1:0]         bkey_q, bkey_d;
  logic [BURST_BITS-1:0] bb_q, bb_d, bi_q, bi_d, sh_q, sh_d;
  logic [QW-1:0]         rem_q, rem_d;
  logic [DCW-1:0]        cnt_q, cnt_d;
  logic [LW-1:0]         lim_q, lim_d, limm_q, limm_d;
  logic [TW-1:0]         acc_q, acc_d, elap_q, elap_d;
  logic [TTW-1:0]        total_q, total_d;

  logic                  ov_q, ov_d, olast_q, olast_d;
  logic [5:0]            oidx_q, oidx_d;
  logic [21:0]           owait_q, owait_d, ofin_q, ofin_d;
  logic [27:0]           otot_q, otot_d;

  logic                  rr, out_free, is_last, elig;
  logic [QW:0]           rem_sh;
  logic [KW-1:0]         key;
  logic [LW-1:0]         bj_ext, lim_sel, bi_ext, q_ext, lim_new;
  logic [TW-1:0]         fin_v, wait_v;
  logic [CW-1:0]         idx_v;
  logic [TTW-1:0]        tot_v;

  assign rr       = (mode_q == bsw_pkg::MODE_RR);
  assign out_free = !ov_q || results_o.ready;
  assign is_last  = ((k_q + CW'(1)) == n_q);
  assign raddr_o  = (state_q == S_RDI) ? k_q[IW-1:0] : j_q[IW-1:0];
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  assign rem_sh  = {rem_q, sh_q[BURST_BITS-1]};
  assign key     = (mode_q == bsw_pkg::MODE_SJF)  ? KW'(rburst_i) :
                   (mode_q == bsw_pkg::MODE_PRIO) ? KW'(rprio_i) : '0;
  // jobs still to run sort after the last one emitted by (key, load index)
  assign elig    = !pv_q || (key > pkey_q) || ((key == pkey_q) && (ridx_q > pidx_q));
  assign bj_ext  = LW'(rburst_i);
  assign lim_sel = (ridx_q <= k_q) ? lim_q : limm_q;
  assign bi_ext  = LW'(bi_q);
  assign q_ext   = LW'(q_q);
  // smallest multiple of the slice that covers the burst, at least one slice
  assign lim_new = (bi_q == '0)  ? q_ext :
                   (rem_q == '0) ? bi_ext : bi_ext + q_ext - LW'(rem_q);

  assign fin_v  = rr ? acc_q : elap_q + TW'(bb_q);
  assign wait_v = rr ? acc_q - TW'(bi_q) : elap_q;
  assign idx_v  = rr ? k_q : bidx_q;
  assign tot_v  = total_q + TTW'(wait_v);

  always_comb begin
    state_d = state_q;
    n_d = n_q; k_d = k_q; j_d = j_q; ridx_d = ridx_q; bidx_d = bidx_q;
    mode_d = mode_q; q_d = q_q; rv_d = 1'b0; bv_d = bv_q;
    pv_d = pv_q; pkey_d = pkey_q; pidx_d = pidx_q;
    bkey_d = bkey_q; bb_d = bb_q; bi_d = bi_q; sh_d = sh_q; rem_d = rem_q;
    cnt_d = cnt_q; lim_d = lim_q; limm_d = limm_q; acc_d = acc_q; elap_d = elap_q;
    total_d = total_q;
    ov_d = ov_q; olast_d = olast_q; oidx_d = oidx_q; owait_d = owait_q;
    ofin_d = ofin_q; otot_d = otot_q;
    stat_o.done = 1'b0;
    stat_o.busy = (state_q != S_IDLE);

    if (ov_q && results_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          n_d     = batch_i.n;
          mode_d  = batch_i.mode;
          q_d     = batch_i.quantum;
          k_d     = '0;
          total_d = '0;
          elap_d  = '0;
          pv_d    = 1'b0;
          j_d     = '0;
          bv_d    = 1'b0;
          acc_d   = '0;
          state_d = (batch_i.mode == bsw_pkg::MODE_RR) ? S_RDI : S_SCAN;
        end
      end
      S_RDI: begin
        state_d = S_LDI;
      end
      S_LDI: begin
        bi_d    = rburst_i;
        sh_d    = rburst_i;
        rem_d   = '0;
        cnt_d   = DCW'(BURST_BITS);
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring remainder, one burst bit per cycle
        if (rem_sh >= {1'b0, q_q}) begin
          rem_d = QW'(rem_sh - {1'b0, q_q});
        end else begin
          rem_d = rem_sh[QW-1:0];
        end
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - DCW'(1);
        if (cnt_q == DCW'(1)) begin
          state_d = S_LIM;
        end
      end
      S_LIM: begin
        lim_d   = lim_new;
        limm_d  = lim_new - q_ext;
        j_d     = '0;
        acc_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q < n_q) begin
          rv_d   = 1'b1;
          ridx_d = j_q;
          j_d    = j_q + CW'(1);
        end
        if (rv_q) begin
          if (rr) begin
            acc_d = acc_q + TW'((bj_ext < lim_sel) ? bj_ext : lim_sel);
          end else if (elig && (!bv_q || key < bkey_q)) begin
            bv_d   = 1'b1;
            bidx_d = ridx_q;
            bkey_d = key;
            bb_d   = rburst_i;
          end
        end
        if (j_q == n_q && !rv_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oidx_d  = 6'(idx_v);
          owait_d = 22'(wait_v);
          ofin_d  = 22'(fin_v);
          olast_d = is_last;
          otot_d  = is_last ? 28'(tot_v) : '0;
          total_d = tot_v;
          elap_d  = fin_v;
          if (!rr) begin
            pv_d   = 1'b1;
            pkey_d = bkey_q;
            pidx_d = bidx_q;
          end
          k_d  = k_q + CW'(1);
          j_d  = '0;
          bv_d = 1'b0;
          acc_d = '0;
          if (is_last) begin
            state_d     = S_IDLE;
            stat_o.done = 1'b1;
          end else begin
            state_d = rr ? S_RDI : S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
      bv_q    <= 1'b0;
      ov_q    <= 1'b0;
      pv_q    <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      mode_q  <= bsw_pkg::MODE_FCFS;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      bv_q    <= bv_d;
      ov_q    <= ov_d;
      pv_q    <= pv_d;
      k_q     <= k_d;
      j_q     <= j_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q  <= ridx_d;
    bidx_q  <= bidx_d;
    pkey_q  <= pkey_d;
    pidx_q  <= pidx_d;
    q_q     <= q_d;
    bkey_q  <= bkey_d;
    bb_q    <= bb_d;
    bi_q    <= bi_d;
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    lim_q   <= lim_d;
    limm_q  <= limm_d;
    acc_q   <= acc_d;
    elap_q  <= elap_d;
    total_q <= total_d;
    olast_q <= olast_d;
    oidx_q  <= oidx_d;
    owait_q <= owait_d;
    ofin_q  <= ofin_d;
    otot_q  <= otot_d;
  end

  assign results_o.valid       = ov_q;
  assign results_o.job_index   = oidx_q;
  assign results_o.wait_time   = owait_q;
  assign results_o.turnaround  = ofin_q;
  assign results_o.total_wait  = otot_q;
  assign results_o.last_result = olast_q;

endmodule

@@ tb/sv/tb_batch_schedule_wait_times_top.sv @@
`timescale 1ns / 1ps
module tb_batch_schedule_wait_times_top;

  localparam int NJOBS = 64;

  typedef struct packed {
    logic [5:0]  job_index;
    logic [21:0] wait_time;
    logic [21:0] turnaround;
    logic [27:0] total_wait;
    logic        last_result;
  } sched_word_t;

  class sched_scoreboard;
    logic [1:0]  mode;
    logic [15:0] quantum;
    logic [15:0] burst[NJOBS];
    logic [7:0]  prio[NJOBS];
    int          count;
    sched_word_t pending[$];
    int          errors;

    function new();
      mode = bsw_pkg::MODE_FCFS;
      quantum = 16'd1;
      count = 0;
      errors = 0;
    endfunction

    function void note_job(logic [15:0] b, logic [7:0] p, logic lastj);
      int order[NJOBS];
      longint fin[NJOBS];
      longint rem[NJOBS];
      bit done[NJOBS];
      longint clock_t, q, minrem, active, k, total, w;
      int n, i, j, cur, completed;
      sched_word_t r;
      burst[count] = b;
      prio[count] = p;
      count++;
      if (!lastj && count < NJOBS) return;
      n = count;
      clock_t = 0;
      for (i = 0; i < n; i++) order[i] = i;
      if (mode == bsw_pkg::MODE_RR) begin
        q = (quantum == 0) ? 1 : quantum;
        completed = 0;
        for (i = 0; i < n; i++) begin
          rem[i] = burst[i];
          done[i] = 0;
        end
        while (completed < n) begin
          minrem = 64'h7fffffffffffffff;
          active = 0;
          for (i = 0; i < n; i++)
            if (!done[i]) begin
              active++;
              if (rem[i] < minrem) minrem = rem[i];
            end
          // jump over passes where nobody can finish
          if (minrem > 0) begin
            k = (minrem - 1) / q;
            if (k > 0) begin
              clock_t += k * q * active;
              for (i = 0; i < n; i++) if (!done[i]) rem[i] -= k * q;
            end
          end
          for (i = 0; i < n; i++) begin
            if (done[i]) continue;
            if (rem[i] <= q) begin
              clock_t += rem[i];
              rem[i] = 0;
              fin[i] = clock_t;
              done[i] = 1;
              completed++;
            end else begin
              clock_t += q;
              rem[i] -= q;
            end
          end
        end
      end else begin
        if (mode != bsw_pkg::MODE_FCFS) begin
          // stable insertion sort
          for (i = 1; i < n; i++) begin
            cur = order[i];
            j = i;
            while (j > 0) begin
              if (mode == bsw_pkg::MODE_SJF ? burst[order[j-1]] <= burst[cur]
                                            : prio[order[j-1]] <= prio[cur]) break;
              order[j] = order[j-1];
              j--;
            end
            order[j] = cur;
          end
        end
        for (i = 0; i < n; i++) begin
          clock_t += burst[order[i]];
          fin[order[i]] = clock_t;
        end
      end
      total = 0;
      for (i = 0; i < n; i++) begin
        cur = order[i];
        w = fin[cur] - burst[cur];
        total += w;
        r.job_index = cur[5:0];
        r.wait_time = w[21:0];
        r.turnaround = fin[cur][21:0];
        r.total_wait = (i == n - 1) ? total[27:0] : '0;
        r.last_result = (i == n - 1);
        pending.insert(pending.size(), r);
      end
      count = 0;
    endfunction

    function void check_word(sched_word_t got);
      sched_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word idx=%0d", got.job_index);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.job_index !== e.job_index) begin
        $error("job_index exp %0d got %0d", e.job_index, got.job_index); errors++;
      end
      if (got.wait_time !== e.wait_time) begin
        $error("wait_time exp %0d got %0d", e.wait_time, got.wait_time); errors++;
      end
      if (got.turnaround !== e.turnaround) begin
        $error("turnaround exp %0d got %0d", e.turnaround, got.turnaround); errors++;
      end
      if (got.total_wait !== e.total_wait) begin
        $error("total_wait exp %0d got %0d", e.total_wait, got.total_wait); errors++;
      end
      if (got.last_result !== e.last_result) begin
        $error("last_result exp %0d got %0d", e.last_result, got.last_result); errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  bsw_in_if jobs();
  bsw_out_if results();

  batch_schedule_wait_times_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .jobs_i(jobs.sink), .results_o(results.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sched_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  longint cycles;
  int items_sent;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 64'd3000000) begin
        $display("[batch_schedule_wait_times_top] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    results.ready = 0;
    forever begin
      @(negedge clk_i);
      results.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && results.valid && results.ready)
      sb.check_word({results.job_index, results.wait_time, results.turnaround,
                     results.total_wait, results.last_result});

  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == bsw_pkg::REG_MODE) sb.mode = val[1:0];
    else sb.quantum = val[15:0];
  endtask

  // offers one word; holds it until accepted
  task automatic send_job(logic [15:0] b, logic [7:0] p, logic lastj);
    while ($urandom_range(99) < send_idle_pct) begin
      jobs.valid = 0;
      @(negedge clk_i);
    end
    jobs.valid = 1;
    jobs.burst_time = b;
    jobs.job_priority = p;
    jobs.last_job = lastj;
    do @(posedge clk_i); while (!jobs.ready);
    sb.note_job(b, p, lastj);
    items_sent++;
    @(negedge clk_i);
    jobs.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    // scheduler may still be wrapping up
    repeat (50) @(posedge clk_i);
  endtask

  task automatic rand_batch(int n, bit wide);
    logic [15:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: b = 16'($urandom_range(3));
        1: b = wide ? 16'($urandom) : 16'($urandom_range(40));
        2: b = 16'($urandom_range(300));
        default: b = wide ? 16'hffff : 16'($urandom_range(8));
      endcase
      send_job(b, ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
               i == n - 1);
    end
  endtask

  initial begin
    logic [15:0] quants[6];
    int n;
    sb = new();
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    jobs.valid = 0; jobs.burst_time = '0; jobs.job_priority = '0; jobs.last_job = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: one batch per mode with extremes, ties and zero bursts
    for (int m = 0; m < 4; m++) begin
      reg_write(bsw_pkg::REG_MODE, m);
      if (m == bsw_pkg::MODE_RR) reg_write(bsw_pkg::REG_QUANTUM, 0);
      send_job(16'hffff, 8'hff, 0);
      send_job(16'd0, 8'h00, 0);
      send_job(16'd5, 8'h80, 0);
      send_job(16'd5, 8'h80, 0);
      send_job(16'd1, 8'h7f, 1);
      drain();
    end
    reg_write(bsw_pkg::REG_QUANTUM, 32'hffff);
    send_job(16'd0, 8'd1, 1);
    drain();
    // store full closes the batch without last_job
    reg_write(bsw_pkg::REG_MODE, 32'(bsw_pkg::MODE_SJF));
    for (int i = 0; i < NJOBS; i++) send_job(16'($urandom_range(20)), 8'($urandom), 0);
    drain();

    quants = '{16'd1, 16'd2, 16'd7, 16'd64, 16'd1000, 16'hffff};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 18 : 0;
      for (int k = 0; k < 10; k++) begin
        // registers change only with nothing in flight
        drain();
        reg_write(bsw_pkg::REG_MODE, $urandom_range(3));
        reg_write(bsw_pkg::REG_QUANTUM, 32'(quants[$urandom_range(5)]));
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
        if (ph == 2 && k == 0) begin
          // long receiver hold-off while a batch streams in
          fork
            begin hold_off = 1; repeat (400) @(posedge clk_i); hold_off = 0; end
            rand_batch(n, k[0]);
          join
          rand_batch(3, 0);
        end else begin
          rand_batch(n, k[0]);
        end
        if (k % 3 == 2) drain();
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[batch_schedule_wait_times_top] OK");
    else
      $display("[batch_schedule_wait_times_top] ERROR");
    $finish;
  end
endmodule
